// ===== hw/rtl/clns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Shared types, operation and register codes, and the init command table.
// ----------------------------------------------------------------------------
package clns_pkg;

  localparam int unsigned SeqLen      = 6;
  localparam int unsigned InitSteps   = 6;
  localparam int unsigned InitCmds    = (InitSteps > SeqLen) ? SeqLen : InitSteps;
  // One power-up beat plus four beats per init command.
  localparam int unsigned InitLast    = 4 * InitCmds;
  localparam int unsigned StepW       = $clog2(InitLast + 1);

  localparam logic [15:0] PowerupWait = 16'd3200;
  localparam logic [7:0]  Line2Cmd    = 8'hC0;
  localparam logic [15:0] HoldMax     = 16'hFFFF;
  localparam logic [6:0]  CountMax    = 7'd127;

  localparam logic [1:0] OpInit = 2'd0;
  localparam logic [1:0] OpCmd  = 2'd1;
  localparam logic [1:0] OpChar = 2'd2;
  localparam logic [1:0] OpNone = 2'd3;

  typedef enum logic [1:0] {
    CFG_PULSE  = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_GAP    = 2'd2,
    CFG_WRAP   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       string_start;
  } in_t;

  typedef struct packed {
    logic [3:0]  data_nibble;
    logic        register_select;
    logic        enable_line;
    logic [15:0] hold_ticks;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] byte_gap_ticks;
    logic [6:0]  wrap_column;
  } cfg_t;

  // Item held while its beats are being produced.
  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       byte_value;
    logic [StepW-1:0] last_step;
  } item_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0C;
      3'd4:    c = 8'h06;
      3'd5:    c = 8'h01;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [14:0] init_wait(input logic [2:0] idx);
    logic [14:0] w;
    unique case (idx)
      3'd0, 3'd1, 3'd2: w = 15'd30000;
      3'd3, 3'd4:       w = 15'd800;
      3'd5:             w = 15'd10000;
      default:          w = 15'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/clns_char_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String character counter
// Counts characters of the current string and flags the wrap character.
// ----------------------------------------------------------------------------
module clns_char_count (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_accept_i,
  input  logic       string_start_i,
  input  logic [6:0] wrap_column_i,
  output logic       wrap_o
);

  logic [6:0] count_q, count_d;
  logic [6:0] base;

  always_comb begin
    base    = string_start_i ? 7'd0 : count_q;
    count_d = base;
    wrap_o  = 1'b0;
    if (base != clns_pkg::CountMax) begin
      count_d = base + 7'd1;
      wrap_o  = (count_d == wrap_column_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (char_accept_i) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/clns_step_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin-state generator
// Maps the held item and its beat index to one pin-state result.
// ----------------------------------------------------------------------------
module clns_step_gen (
  input  clns_pkg::item_t                item_i,
  input  logic [clns_pkg::StepW-1:0]     step_i,
  input  clns_pkg::cfg_t                 cfg_i,
  output clns_pkg::out_t                 out_o
);

  logic [clns_pkg::StepW-1:0] j;
  logic [1:0]  sub;
  logic [7:0]  bval;
  logic        rs;
  logic [14:0] extra;
  logic [17:0] long_sum;
  logic [15:0] long_hold;
  logic        powerup;

  always_comb begin
    j       = step_i - clns_pkg::StepW'(1);
    sub     = step_i[1:0];
    bval    = item_i.byte_value;
    rs      = 1'b0;
    extra   = '0;
    powerup = 1'b0;
    unique case (item_i.operation)
      clns_pkg::OpInit: begin
        powerup = (step_i == '0);
        sub     = j[1:0];
        bval    = clns_pkg::init_cmd(3'(j >> 2));
        extra   = clns_pkg::init_wait(3'(j >> 2));
      end
      clns_pkg::OpChar: begin
        // The second byte of a character item is the second-line command.
        if (step_i[2]) begin
          bval = clns_pkg::Line2Cmd;
        end else begin
          rs = 1'b1;
        end
      end
      default: begin
      end
    endcase

    long_sum  = 18'(cfg_i.settle_ticks) + 18'(cfg_i.byte_gap_ticks) + 18'(extra);
    long_hold = (long_sum > 18'(clns_pkg::HoldMax)) ? clns_pkg::HoldMax : long_sum[15:0];

    out_o.last = (step_i == item_i.last_step);
    if (powerup) begin
      out_o.data_nibble     = 4'h0;
      out_o.register_select = 1'b0;
      out_o.enable_line     = 1'b0;
      out_o.hold_ticks      = clns_pkg::PowerupWait;
    end else begin
      out_o.data_nibble     = sub[1] ? bval[3:0] : bval[7:4];
      out_o.register_select = rs;
      out_o.enable_line     = ~sub[0];
      if (!sub[0]) begin
        out_o.hold_ticks = cfg_i.pulse_ticks;
      end else if (sub[1]) begin
        out_o.hold_ticks = long_hold;
      end else begin
        out_o.hold_ticks = cfg_i.settle_ticks;
      end
    end
  end

endmodule

// ===== hw/rtl/char_lcd_nibble_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Expands init, command and character items into 4-bit LCD pin states.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one item
//   per beat: init, command byte or string character. The output channel
//   (out_valid_o / out_ready_i / out_data_o) gives one pin state per beat;
//   the final beat of an item carries last.
//   A command or character without wrap gives 4 beats, a character that
//   reaches the wrap column gives 8, and init gives 25. Each item is held
//   in the item register, and its beats move from there into the output
//   register one beat per cycle while the receiver does not stall.
//   The next item is accepted in the cycle that moves the current item's
//   final beat into the output register, so items follow back to back.
//   Operation code 3 is accepted and gives no beats.
//   When the receiver stalls, the output register holds its beat and the
//   held item waits; the input stays not ready until its final beat moves on.
//   Reset empties both registers, clears the character count and loads
//   the default timing and wrap settings. Configuration writes take effect
//   at once; the user makes them only while the block is idle, not enforced.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  clns_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output clns_pkg::out_t     out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  clns_pkg::cfg_t  cfg_q;
  clns_pkg::item_t item_q, item_d;
  logic [clns_pkg::StepW-1:0] step_q, step_d;
  logic            busy_q, busy_d;
  logic            out_valid_q;
  clns_pkg::out_t  out_q;
  clns_pkg::out_t  gen_out;
  logic            advance, finish, in_accept, wrap;
  logic [clns_pkg::StepW-1:0] load_last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_ticks    <= 16'd25;
      cfg_q.settle_ticks   <= 16'd1000;
      cfg_q.byte_gap_ticks <= 16'd1000;
      cfg_q.wrap_column    <= 7'd16;
    end else if (cfg_we_i) begin
      unique case (clns_pkg::cfg_idx_e'(cfg_idx_i))
        clns_pkg::CFG_PULSE:  cfg_q.pulse_ticks    <= cfg_wdata_i;
        clns_pkg::CFG_SETTLE: cfg_q.settle_ticks   <= cfg_wdata_i;
        clns_pkg::CFG_GAP:    cfg_q.byte_gap_ticks <= cfg_wdata_i;
        clns_pkg::CFG_WRAP:   cfg_q.wrap_column    <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = busy_q && (!out_valid_q || out_ready_i);
  assign finish     = advance && (step_q == item_q.last_step);
  assign in_ready_o = !busy_q || finish;
  assign in_accept  = in_valid_i && in_ready_o;

  clns_char_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_accept_i  (in_accept && (in_data_i.operation == clns_pkg::OpChar)),
    .string_start_i (in_data_i.string_start),
    .wrap_column_i  (cfg_q.wrap_column),
    .wrap_o         (wrap)
  );

  always_comb begin
    unique case (in_data_i.operation)
      clns_pkg::OpInit: load_last = clns_pkg::StepW'(clns_pkg::InitLast);
      clns_pkg::OpChar: load_last = wrap ? clns_pkg::StepW'(7) : clns_pkg::StepW'(3);
      default:          load_last = clns_pkg::StepW'(3);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    item_d = item_q;
    step_d = step_q;
    if (in_accept && (in_data_i.operation != clns_pkg::OpNone)) begin
      busy_d           = 1'b1;
      item_d.operation  = in_data_i.operation;
      item_d.byte_value = in_data_i.byte_value;
      item_d.last_step  = load_last;
      step_d           = '0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (advance) begin
      step_d = step_q + clns_pkg::StepW'(1);
    end
  end

  clns_step_gen u_gen (
    .item_i (item_q),
    .step_i (step_q),
    .cfg_i  (cfg_q),
    .out_o  (gen_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (advance) begin
      out_q <= gen_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The beat index never runs past the final beat of the held item.
  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= item_q.last_step))
    else $error("beat index beyond final beat");

  // An item with no beats never occupies the sequencer.
  a_none_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !busy_q && (in_data_i.operation == clns_pkg::OpNone)) |=> !busy_q)
    else $error("empty item occupied the sequencer");

  // A beat marked last always frees the input side in the same cycle.
  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && gen_out.last) |-> in_ready_o)
    else $error("last beat without input ready");

endmodule
